FILE: sv/prau_pkg.sv
// Shared constants and register map for the Pauli rotation amplitude pair unit.
package prau_pkg;

    localparam int INDEX_BITS_DEF  = 20;
    localparam int AMP_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int REG_IDX_W       = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FLIP_MASK      = 3'd0,
        REG_PHASE_MASK     = 3'd1,
        REG_Y_COUNT_MOD4   = 3'd2,
        REG_CONTROL_SELECT = 3'd3,
        REG_CONTROL_VALUE  = 3'd4,
        REG_COS_HALF       = 3'd5,
        REG_SIN_HALF       = 3'd6
    } t_reg_idx;

endpackage

FILE: sv/prau_front.sv
// Front end: classify a request, form the partner index and the turned amplitudes.
module prau_front import prau_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int AMP_BITS   = AMP_BITS_DEF,
    parameter int ENTRY_W    = INDEX_BITS + 1 + 8 * AMP_BITS + 4
) (
    input  logic                       i_start,
    input  logic                       i_full,
    input  logic [INDEX_BITS-1:0]      i_first_index,
    input  logic signed [AMP_BITS-1:0] i_a_real,
    input  logic signed [AMP_BITS-1:0] i_a_imag,
    input  logic signed [AMP_BITS-1:0] i_b_real,
    input  logic signed [AMP_BITS-1:0] i_b_imag,
    input  logic [INDEX_BITS-1:0]      i_flip_mask,
    input  logic [INDEX_BITS-1:0]      i_phase_mask,
    input  logic [1:0]                 i_y_count_mod4,
    input  logic [INDEX_BITS-1:0]      i_control_select,
    input  logic [INDEX_BITS-1:0]      i_control_value,
    output logic                       o_push,
    output logic [ENTRY_W-1:0]         o_entry
);

    localparam int W = AMP_BITS;

    typedef struct packed {
        logic [INDEX_BITS-1:0] partner;
        logic                  go;
        logic signed [W-1:0]   ar;
        logic signed [W-1:0]   ai;
        logic signed [W-1:0]   br;
        logic signed [W-1:0]   bi;
        logic signed [W:0]     ta_r;
        logic signed [W:0]     ta_i;
        logic signed [W:0]     tb_r;
        logic signed [W:0]     tb_i;
    } t_entry;

    // Multiply (re, im) by i^q, one extra bit keeps the negated minimum exact.
    function automatic logic signed [2*W+1:0] turn(input logic signed [W-1:0] re,
                                                   input logic signed [W-1:0] im,
                                                   input logic [1:0] q);
        logic signed [W:0] xr;
        logic signed [W:0] xi;
        logic signed [W:0] orr;
        logic signed [W:0] oi;
        xr = {re[W-1], re};
        xi = {im[W-1], im};
        case (q)
            2'd0: begin
                orr = xr;  oi = xi;
            end
            2'd1: begin
                orr = -xi; oi = xr;
            end
            2'd2: begin
                orr = -xr; oi = -xi;
            end
            default: begin
                orr = xi;  oi = -xr;
            end
        endcase
        return {orr, oi};
    endfunction

    logic [INDEX_BITS-1:0] partner;
    logic                  diag;
    logic                  go;
    logic [1:0]            q_a;
    logic [1:0]            q_b;
    logic signed [W-1:0]   eff_br;
    logic signed [W-1:0]   eff_bi;
    t_entry                entry;

    assign partner = i_first_index ^ i_flip_mask;
    assign diag    = (i_flip_mask == '0);
    assign go      = ((i_first_index & i_control_select) == i_control_value)
                     && (diag || (i_first_index < partner));

    // Quarter plus three, taken modulo four by the 2-bit add.
    assign q_a = {^(i_first_index & i_phase_mask), 1'b0} + i_y_count_mod4 + 2'd3;
    assign q_b = {^(partner & i_phase_mask), 1'b0} + i_y_count_mod4 + 2'd3;

    // With no flip the partner is the first amplitude itself.
    assign eff_br = diag ? i_a_real : i_b_real;
    assign eff_bi = diag ? i_a_imag : i_b_imag;

    always_comb begin
        entry.partner        = partner;
        entry.go             = go;
        entry.ar             = i_a_real;
        entry.ai             = i_a_imag;
        entry.br             = eff_br;
        entry.bi             = eff_bi;
        {entry.ta_r, entry.ta_i} = turn(eff_br, eff_bi, q_b);
        {entry.tb_r, entry.tb_i} = turn(i_a_real, i_a_imag, q_a);
    end

    assign o_push  = i_start && !i_full;
    assign o_entry = entry;

endmodule

FILE: sv/prau_queue.sv
// Small first-in first-out queue between the front and back ends.
module prau_queue import prau_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

endmodule

FILE: sv/prau_back.sv
// Back end: multiply stage, then round, saturate and drive the result.
module prau_back import prau_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int AMP_BITS   = AMP_BITS_DEF,
    parameter int ENTRY_W    = INDEX_BITS + 1 + 8 * AMP_BITS + 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [ENTRY_W-1:0]         i_entry,
    input  logic signed [AMP_BITS-1:0] i_cos_half,
    input  logic signed [AMP_BITS-1:0] i_sin_half,
    output logic                       o_pop,
    output logic                       o_strobe,
    output logic [INDEX_BITS-1:0]      o_partner_index,
    output logic                       o_updated,
    output logic signed [AMP_BITS-1:0] o_new_a_real,
    output logic signed [AMP_BITS-1:0] o_new_a_imag,
    output logic signed [AMP_BITS-1:0] o_new_b_real,
    output logic signed [AMP_BITS-1:0] o_new_b_imag
);

    localparam int W  = AMP_BITS;
    localparam int SW = 2 * W + 2;
    localparam int RW = W + 3;
    localparam logic signed [SW-1:0] HALF = {{(SW - W + 1){1'b0}}, 1'b1, {(W - 2){1'b0}}};
    localparam logic signed [RW-1:0] HI   = {4'b0000, {(W - 1){1'b1}}};
    localparam logic signed [RW-1:0] LO   = {4'b1111, {(W - 1){1'b0}}};

    typedef struct packed {
        logic [INDEX_BITS-1:0] partner;
        logic                  go;
        logic signed [W-1:0]   ar;
        logic signed [W-1:0]   ai;
        logic signed [W-1:0]   br;
        logic signed [W-1:0]   bi;
        logic signed [W:0]     ta_r;
        logic signed [W:0]     ta_i;
        logic signed [W:0]     tb_r;
        logic signed [W:0]     tb_i;
    } t_entry;

    function automatic logic signed [W-1:0] round_sat(input logic signed [2*W-1:0] p1,
                                                      input logic signed [2*W:0]   p2);
        logic signed [SW-1:0] s;
        logic signed [RW-1:0] r;
        logic signed [W-1:0]  res;
        s = $signed({{2{p1[2*W-1]}}, p1}) + $signed({p2[2*W], p2}) + HALF;
        r = s[SW-1:W-1];
        if (r > HI) begin
            res = HI[W-1:0];
        end else if (r < LO) begin
            res = LO[W-1:0];
        end else begin
            res = r[W-1:0];
        end
        return res;
    endfunction

    t_entry e;
    assign e = i_entry;

    // Multiply stage
    logic                   r_m_valid;
    logic                   r_m_go;
    logic [INDEX_BITS-1:0]  r_m_partner;
    logic signed [W-1:0]    r_m_ar, r_m_ai, r_m_br, r_m_bi;
    logic signed [2*W-1:0]  r_c_ar, r_c_ai, r_c_br, r_c_bi;
    logic signed [2*W:0]    r_s_ar, r_s_ai, r_s_br, r_s_bi;

    assign o_pop = i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_go      <= e.go;
        r_m_partner <= e.partner;
        r_m_ar      <= e.ar;
        r_m_ai      <= e.ai;
        r_m_br      <= e.br;
        r_m_bi      <= e.bi;
        r_c_ar      <= i_cos_half * e.ar;
        r_c_ai      <= i_cos_half * e.ai;
        r_c_br      <= i_cos_half * e.br;
        r_c_bi      <= i_cos_half * e.bi;
        r_s_ar      <= i_sin_half * e.ta_r;
        r_s_ai      <= i_sin_half * e.ta_i;
        r_s_br      <= i_sin_half * e.tb_r;
        r_s_bi      <= i_sin_half * e.tb_i;
    end

    // Round and output stage
    logic                  r_strobe;
    logic [INDEX_BITS-1:0] r_partner;
    logic                  r_updated;
    logic signed [W-1:0]   r_nar, r_nai, r_nbr, r_nbi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_partner <= r_m_partner;
        r_updated <= r_m_go;
        r_nar     <= r_m_go ? round_sat(r_c_ar, r_s_ar) : r_m_ar;
        r_nai     <= r_m_go ? round_sat(r_c_ai, r_s_ai) : r_m_ai;
        r_nbr     <= r_m_go ? round_sat(r_c_br, r_s_br) : r_m_br;
        r_nbi     <= r_m_go ? round_sat(r_c_bi, r_s_bi) : r_m_bi;
    end

    assign o_strobe        = r_strobe;
    assign o_partner_index = r_partner;
    assign o_updated       = r_updated;
    assign o_new_a_real    = r_nar;
    assign o_new_a_imag    = r_nai;
    assign o_new_b_real    = r_nbr;
    assign o_new_b_imag    = r_nbi;

endmodule

FILE: sv/pauli_rotation_amplitude_pair_unit.sv
// A request accepted at a clock edge is written into the queue, then registered in the multiply
// stage and in the round stage before it shows on o_strobe, where the receiver takes it.
// Throughput: one amplitude pair per cycle; the multiply stage and the round stage never stall.
// busy rises only if the two-entry queue fills, which a non-stalling back end never lets happen.
// Reset (i_rst_n low, synchronous): queue emptied, pipeline valid bits cleared, registers
// return to flip/phase/control masks zero, cos_half at its maximum and sin_half zero.
module pauli_rotation_amplitude_pair_unit import prau_pkg::*; #(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int AMP_BITS    = AMP_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int DATA_W     = (INDEX_BITS > 32 || AMP_BITS > 32) ? 64 : 32,
    localparam int ADDR_LSB   = (DATA_W == 64) ? 3 : 2,
    localparam int ADDR_W     = ADDR_LSB + REG_IDX_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       start,
    output logic                       busy,
    input  logic [INDEX_BITS-1:0]      i_first_index,
    input  logic signed [AMP_BITS-1:0] i_a_real,
    input  logic signed [AMP_BITS-1:0] i_a_imag,
    input  logic signed [AMP_BITS-1:0] i_b_real,
    input  logic signed [AMP_BITS-1:0] i_b_imag,
    // result channel
    output logic                       o_strobe,
    output logic [INDEX_BITS-1:0]      o_partner_index,
    output logic                       o_updated,
    output logic signed [AMP_BITS-1:0] o_new_a_real,
    output logic signed [AMP_BITS-1:0] o_new_a_imag,
    output logic signed [AMP_BITS-1:0] o_new_b_real,
    output logic signed [AMP_BITS-1:0] o_new_b_imag,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    localparam int ENTRY_W = INDEX_BITS + 1 + 8 * AMP_BITS + 4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [INDEX_BITS-1:0]      r_flip_mask;
    logic [INDEX_BITS-1:0]      r_phase_mask;
    logic [1:0]                 r_y_count_mod4;
    logic [INDEX_BITS-1:0]      r_control_select;
    logic [INDEX_BITS-1:0]      r_control_value;
    logic signed [AMP_BITS-1:0] r_cos_half;
    logic signed [AMP_BITS-1:0] r_sin_half;

    t_reg_idx reg_idx;
    logic     cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[ADDR_W-1:ADDR_LSB]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Write on the access phase; values are cut to register width, unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_mask      <= '0;
            r_phase_mask     <= '0;
            r_y_count_mod4   <= '0;
            r_control_select <= '0;
            r_control_value  <= '0;
            r_cos_half       <= {1'b0, {(AMP_BITS - 1){1'b1}}};
            r_sin_half       <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_FLIP_MASK:      r_flip_mask      <= pwdata[INDEX_BITS-1:0];
                REG_PHASE_MASK:     r_phase_mask     <= pwdata[INDEX_BITS-1:0];
                REG_Y_COUNT_MOD4:   r_y_count_mod4   <= pwdata[1:0];
                REG_CONTROL_SELECT: r_control_select <= pwdata[INDEX_BITS-1:0];
                REG_CONTROL_VALUE:  r_control_value  <= pwdata[INDEX_BITS-1:0];
                REG_COS_HALF:       r_cos_half       <= pwdata[AMP_BITS-1:0];
                REG_SIN_HALF:       r_sin_half       <= pwdata[AMP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back raw register bits, zero-extended.
    always_comb begin
        case (reg_idx)
            REG_FLIP_MASK:      prdata = DATA_W'(r_flip_mask);
            REG_PHASE_MASK:     prdata = DATA_W'(r_phase_mask);
            REG_Y_COUNT_MOD4:   prdata = DATA_W'(r_y_count_mod4);
            REG_CONTROL_SELECT: prdata = DATA_W'(r_control_select);
            REG_CONTROL_VALUE:  prdata = DATA_W'(r_control_value);
            REG_COS_HALF:       prdata = DATA_W'($unsigned(r_cos_half));
            REG_SIN_HALF:       prdata = DATA_W'($unsigned(r_sin_half));
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: classify each request and push it into the queue
    // ------------------------------------------------------------------
    logic               push;
    logic [ENTRY_W-1:0] push_entry;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_entry;

    prau_front #(
        .INDEX_BITS (INDEX_BITS),
        .AMP_BITS   (AMP_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_start          (start),
        .i_full           (q_full),
        .i_first_index    (i_first_index),
        .i_a_real         (i_a_real),
        .i_a_imag         (i_a_imag),
        .i_b_real         (i_b_real),
        .i_b_imag         (i_b_imag),
        .i_flip_mask      (r_flip_mask),
        .i_phase_mask     (r_phase_mask),
        .i_y_count_mod4   (r_y_count_mod4),
        .i_control_select (r_control_select),
        .i_control_value  (r_control_value),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    // Hold off new requests only while the queue is full.
    assign busy = q_full;

    prau_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_entry)
    );

    // ------------------------------------------------------------------
    // Back end: drain one entry per cycle through multiply and round
    // ------------------------------------------------------------------
    prau_back #(
        .INDEX_BITS (INDEX_BITS),
        .AMP_BITS   (AMP_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_entry         (q_entry),
        .i_cos_half      (r_cos_half),
        .i_sin_half      (r_sin_half),
        .o_pop           (q_pop),
        .o_strobe        (o_strobe),
        .o_partner_index (o_partner_index),
        .o_updated       (o_updated),
        .o_new_a_real    (o_new_a_real),
        .o_new_a_imag    (o_new_a_imag),
        .o_new_b_real    (o_new_b_real),
        .o_new_b_imag    (o_new_b_imag)
    );

`ifndef ASSERT_OFF
    // Every accepted request leaves as a result on o_strobe after the queue and both back-end stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_strobe)
        else $error("accepted request produced no result on time");

    // The back end never stalls, so the queue must never fill.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue filled up");

    // An updated pair must have the first index below its partner.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_updated && (r_flip_mask != '0))
            |-> ((o_partner_index ^ r_flip_mask) < o_partner_index))
        else $error("rotation applied to an out-of-order pair");

    // With no flip both result amplitudes must match.
    a_diag_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_flip_mask == '0))
            |-> (o_new_b_real == o_new_a_real && o_new_b_imag == o_new_a_imag))
        else $error("diagonal result amplitudes differ");
`endif

endmodule
